// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file bee_checker.sv.
// Expects signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on clk, off during reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Expression that must never be true.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_PROP(lbl, !(expr))

`endif

// ----- sv/bee_pkg.sv -----
// Package for the byte escape encoder: character codes, mode bits, run type and hex digit function.
// No dependencies.
`default_nettype none

package bee_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] mode_t;
  typedef logic [2:0] count_t;

  localparam int RunLen = 4;

  localparam char_t CHAR_BACKSLASH = 8'h5C;
  localparam char_t CHAR_SQUOTE    = 8'h27;
  localparam char_t CHAR_DQUOTE    = 8'h22;
  localparam char_t CHAR_SPACE     = 8'h20;
  localparam char_t CHAR_TILDE     = 8'd126;
  localparam char_t CHAR_X         = 8'h78;
  localparam char_t CHAR_DOT       = 8'h2E;
  localparam char_t CHAR_ZERO      = 8'h30;
  localparam char_t CHAR_LOWER_A   = 8'h61;

  localparam int MODE_BACKSLASH = 0;
  localparam int MODE_QUOTE     = 1;
  localparam int MODE_HEX       = 2;
  localparam int MODE_DOT       = 3;

  // Characters of one rendered byte, chars[0] goes out first.
  typedef struct packed {
    logic [RunLen-1:0][7:0] chars;
    count_t                 count;
  } run_t;

  function automatic char_t hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_digit = CHAR_ZERO + char_t'(nib);
    end else begin
      hex_digit = CHAR_LOWER_A + char_t'(nib - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/bee_expand.sv -----
// Renders one byte into its run of one to four characters per the mode bits.
// Depends on bee_pkg.
`default_nettype none

module bee_expand import bee_pkg::*; (
  input  char_t in_byte,
  input  mode_t mode,
  output run_t  run
);

  logic non_printable;

  assign non_printable = !(in_byte inside {[CHAR_SPACE:CHAR_TILDE]});

  always_comb begin
    run.chars = '0;
    run.count = count_t'(1);
    if (in_byte == CHAR_BACKSLASH && mode[MODE_BACKSLASH]) begin
      run.chars[0] = CHAR_BACKSLASH;
      run.chars[1] = CHAR_BACKSLASH;
      run.count    = count_t'(2);
    end else if ((in_byte inside {CHAR_SQUOTE, CHAR_DQUOTE}) && mode[MODE_QUOTE]) begin
      run.chars[0] = CHAR_BACKSLASH;
      run.chars[1] = in_byte;
      run.count    = count_t'(2);
    end else if (non_printable && mode[MODE_HEX]) begin
      run.chars[0] = CHAR_BACKSLASH;
      run.chars[1] = CHAR_X;
      run.chars[2] = hex_digit(in_byte[7:4]);
      run.chars[3] = hex_digit(in_byte[3:0]);
      run.count    = count_t'(4);
    end else if (non_printable && mode[MODE_DOT]) begin
      run.chars[0] = CHAR_DOT;
    end else begin
      run.chars[0] = in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bee_emit.sv -----
// Run buffer and result register: sends one character of the run per cycle.
// Depends on bee_pkg.
`default_nettype none

module bee_emit import bee_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load_valid,
  input  run_t  run,
  input  logic  run_eos,
  output logic  load_ready,
  output logic  result_strobe,
  output char_t out_char,
  output logic  last_of_run,
  output logic  string_done
);

  logic [RunLen-1:0][7:0] chars;
  count_t                 remain;
  logic                   eos;
  logic                   load;

  // Free next cycle if empty or sending its last character now.
  assign load_ready = (remain == count_t'(0)) || (remain == count_t'(1));
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain        <= '0;
      result_strobe <= 1'b0;
      last_of_run   <= 1'b0;
      string_done   <= 1'b0;
    end else begin
      result_strobe <= (remain != count_t'(0));
      last_of_run   <= (remain == count_t'(1));
      string_done   <= (remain == count_t'(1)) && eos;
      if (load) begin
        remain <= run.count;
      end else if (remain != count_t'(0)) begin
        remain <= remain - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char <= chars[0];
    if (load) begin
      chars <= run.chars;
      eos   <= run_eos;
    end else begin
      chars <= {char_t'(0), chars[RunLen-1:1]};
    end
  end

endmodule

`default_nettype wire

// ----- sv/byte_escape_encoder.sv -----
// When the encoder is empty, an accepted request passes the request register and
// the run buffer before its first character reaches the result register. A byte
// renders as 1, 2 or 4 characters, one per cycle from the run buffer. A request
// waits in the request register while the previous run drains; busy then refuses
// start until it is loaded. Synchronous reset clears the mode register (all
// escapes off) and empties every stage; results cannot be stalled by the receiver.
`default_nettype none

module byte_escape_encoder import bee_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  char_t in_byte,
  input  logic  end_of_string,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  mode_t cfg_data,
  output logic  result_strobe,
  output char_t out_char,
  output logic  last_of_run,
  output logic  string_done
);

  mode_t mode;
  logic  req_valid;
  char_t req_byte;
  logic  req_eos;
  logic  load_ready;
  run_t  run;

  assign cfg_ready = 1'b1;
  assign busy      = req_valid && !load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (start && !busy) begin
      req_valid <= 1'b1;
    end else if (load_ready) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_byte <= in_byte;
      req_eos  <= end_of_string;
    end
  end

  bee_expand u_expand (
    .in_byte (req_byte),
    .mode    (mode),
    .run     (run)
  );

  bee_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (req_valid),
    .run           (run),
    .run_eos       (req_eos),
    .load_ready    (load_ready),
    .result_strobe (result_strobe),
    .out_char      (out_char),
    .last_of_run   (last_of_run),
    .string_done   (string_done)
  );

endmodule

`default_nettype wire

// ----- sv/bee_checker.sv -----
// Port-level checker for byte_escape_encoder, bound to the top level.
// Depends on bee_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bee_checker import bee_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  start,
  input wire logic  busy,
  input wire char_t in_byte,
  input wire logic  end_of_string,
  input wire logic  cfg_valid,
  input wire logic  cfg_ready,
  input wire mode_t cfg_data,
  input wire logic  result_strobe,
  input wire char_t out_char,
  input wire logic  last_of_run,
  input wire logic  string_done
);

  `ASSERT_NEVER(a_done_marks, string_done && !(last_of_run && result_strobe))
  `ASSERT_PROP(a_first_char, (start && !busy) |=> ##2 result_strobe)
  `ASSERT_PROP(a_busy_drains, busy |=> result_strobe)
  `ASSERT_PROP(a_run_unbroken, (result_strobe && !last_of_run) |=> result_strobe)

endmodule

bind byte_escape_encoder bee_checker u_bee_checker (.*);

`default_nettype wire
